// File: src/pam_hd_pkg.sv
package pam_hd_pkg;

  localparam int LVL_W      = 16;
  localparam int NB_W       = 4;
  localparam int NBE_W      = 5;
  localparam int N_W        = 16;
  localparam int D_W        = LVL_W + 1;
  localparam int Q_W        = LVL_W + 1;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_BITS   = 2'd0,
    REG_MSB_FIRST  = 2'd1,
    REG_HIGH_LEVEL = 2'd2,
    REG_LOW_LEVEL  = 2'd3
  } reg_idx_e;

  localparam logic [NB_W-1:0]  NUM_BITS_RST   = 4'd4;
  localparam logic             MSB_FIRST_RST  = 1'b1;
  localparam logic [LVL_W-1:0] HIGH_LEVEL_RST = 16'h1000;
  localparam logic [LVL_W-1:0] LOW_LEVEL_RST  = 16'hF000;

  // derived settings; the user must keep them stable while the datapath is busy, the block does not enforce it
  typedef struct packed {
    logic [NBE_W-1:0] nb;
    logic             msb_first;
    logic [N_W-1:0]   n;
    logic [D_W-1:0]   d;
    logic             d_zero;
    logic [LVL_W-1:0] lo;
  } cfg_t;

endpackage

// File: src/pam_hd_intf.sv
interface pam_hd_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface pam_hd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            bit_res;
  logic [pam_hd_pkg::LVL_W-1:0]    level;
  logic                            last;
  modport source (output valid, output bit_res, output level, output last, input ready);
  modport sink (input valid, input bit_res, input level, input last, output ready);
endinterface

interface pam_hd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pam_hd_pkg::CFG_ADDR_W-1:0] addr;
  logic [pam_hd_pkg::LVL_W-1:0]      data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// File: src/pam_hd_cfg.sv
module pam_hd_cfg #(
  parameter int MAX_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_valid_i,
  input  logic [pam_hd_pkg::CFG_ADDR_W-1:0] wr_addr_i,
  input  logic [pam_hd_pkg::LVL_W-1:0]      wr_data_i,
  output pam_hd_pkg::cfg_t                  cfg_o
);

  localparam int NB_W  = pam_hd_pkg::NB_W;
  localparam int NBE_W = pam_hd_pkg::NBE_W;
  localparam int N_W   = pam_hd_pkg::N_W;
  localparam int LVL_W = pam_hd_pkg::LVL_W;

  logic [NB_W-1:0]  num_bits_q;
  logic             msb_first_q;
  logic [LVL_W-1:0] high_level_q;
  logic [LVL_W-1:0] low_level_q;
  logic [NBE_W-1:0] nb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bits_q   <= pam_hd_pkg::NUM_BITS_RST;
      msb_first_q  <= pam_hd_pkg::MSB_FIRST_RST;
      high_level_q <= pam_hd_pkg::HIGH_LEVEL_RST;
      low_level_q  <= pam_hd_pkg::LOW_LEVEL_RST;
    end else if (wr_valid_i) begin
      unique case (pam_hd_pkg::reg_idx_e'(wr_addr_i))
        pam_hd_pkg::REG_NUM_BITS:   num_bits_q   <= wr_data_i[NB_W-1:0];
        pam_hd_pkg::REG_MSB_FIRST:  msb_first_q  <= wr_data_i[0];
        pam_hd_pkg::REG_HIGH_LEVEL: high_level_q <= wr_data_i;
        pam_hd_pkg::REG_LOW_LEVEL:  low_level_q  <= wr_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_bits_q == '0) begin
      nb = NBE_W'(1);
    end else if (int'(num_bits_q) > MAX_BITS) begin
      nb = NBE_W'(MAX_BITS);
    end else begin
      nb = NBE_W'(num_bits_q);
    end
  end

  assign cfg_o.nb        = nb;
  assign cfg_o.msb_first = msb_first_q;
  assign cfg_o.n         = N_W'((32'd1 << nb) - 32'd1);
  assign cfg_o.d         = {high_level_q[LVL_W-1], high_level_q}
                         - {low_level_q[LVL_W-1], low_level_q};
  assign cfg_o.d_zero    = (high_level_q == low_level_q);
  assign cfg_o.lo        = low_level_q;

endmodule

// File: src/pam_hd_idx.sv
module pam_hd_idx #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_BITS     = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pam_hd_pkg::cfg_t        cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MAX_BITS-1:0]     idx_o
);

  localparam int LVL_W = pam_hd_pkg::LVL_W;
  localparam int D_W   = pam_hd_pkg::D_W;
  localparam int NBE_W = pam_hd_pkg::NBE_W;
  localparam int XW    = ((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W) + 1;
  localparam int PW    = XW + MAX_BITS + 1;
  localparam int RW    = XW + MAX_BITS + 3;
  localparam int S     = MAX_BITS + 3;

  logic [S-1:0]             v_q;
  logic [S:0]               en;
  logic signed [XW-1:0]     diff_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [RW-1:0]     r_q [MAX_BITS+1];
  logic [MAX_BITS-1:0]      q_q [MAX_BITS+1];

  logic signed [D_W-1:0]    d;
  logic signed [XW-1:0]     x_ext;
  logic signed [XW-1:0]     lo_ext;
  logic signed [MAX_BITS:0] n_s;
  logic signed [RW-1:0]     d_ext;

  assign d      = $signed(cfg_i.d);
  assign x_ext  = XW'($signed(sample_i));
  assign lo_ext = XW'($signed(cfg_i.lo));
  assign n_s    = $signed({1'b0, cfg_i.n[MAX_BITS-1:0]});
  assign d_ext  = RW'(d);

  always_comb begin
    en[S] = out_ready_i;
    for (int k = S - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S-1];
  assign idx_o       = q_q[MAX_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < S; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // numerator 2*(x-lo)*n + d, then restoring search for floor(num / 2d)
  always_ff @(posedge clk_i) begin
    if (en[0]) diff_q <= x_ext - lo_ext;
    if (en[1]) prod_q <= PW'(diff_q) * PW'(n_s);
    if (en[2]) begin
      r_q[0] <= (RW'(prod_q) <<< 1) + d_ext;
      q_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= MAX_BITS; j++) begin : g_step
    localparam int               B    = MAX_BITS - j;
    localparam logic [NBE_W-1:0] BPOS = NBE_W'(B);

    logic signed [RW-1:0] t;
    logic                 take;
    logic [MAX_BITS-1:0]  q_nx;

    assign t    = d_ext <<< (B + 1);
    assign take = (cfg_i.nb > BPOS) && !cfg_i.d_zero
               && (d[D_W-1] ? (r_q[j-1] <= t) : (r_q[j-1] >= t));

    always_comb begin
      q_nx    = q_q[j-1];
      q_nx[B] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en[2+j]) begin
        r_q[j] <= take ? (r_q[j-1] - t) : r_q[j-1];
        q_q[j] <= q_nx;
      end
    end
  end

endmodule

// File: src/pam_hd_lvl.sv
module pam_hd_lvl #(
  parameter int MAX_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pam_hd_pkg::cfg_t             cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [MAX_BITS-1:0]          idx_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [MAX_BITS-1:0]          idx_o,
  output logic [pam_hd_pkg::LVL_W-1:0] level_o
);

  localparam int LVL_W = pam_hd_pkg::LVL_W;
  localparam int D_W   = pam_hd_pkg::D_W;
  localparam int Q_W   = pam_hd_pkg::Q_W;
  localparam int PW    = MAX_BITS + D_W + 1;
  localparam int LW    = MAX_BITS + Q_W + 2;
  localparam int S     = Q_W + 2;

  logic [S-1:0]         v_q;
  logic [S:0]           en;
  logic signed [PW-1:0] p_q;
  logic [LW-1:0]        r_q [Q_W+1];
  logic [Q_W-1:0]       q_q [Q_W+1];
  logic [MAX_BITS-1:0]  i_q [S];
  logic [LW-1:0]        n_ext;

  assign n_ext = LW'(cfg_i.n[MAX_BITS-1:0]);

  always_comb begin
    en[S] = out_ready_i;
    for (int k = S - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S-1];
  assign idx_o       = i_q[S-1];
  // quotient carries a bias of 2^16, which drops out of the 16-bit sum
  assign level_o     = cfg_i.lo + q_q[Q_W][LVL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < S; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q    <= PW'($signed({1'b0, idx_i})) * PW'($signed(cfg_i.d));
      i_q[0] <= idx_i;
    end
    for (int k = 1; k < S; k++) begin
      if (en[k]) i_q[k] <= i_q[k-1];
    end
    // 2*idx*d + n + 2n*2^16, always positive
    if (en[1]) begin
      r_q[0] <= (LW'(p_q) << 1) + n_ext + (n_ext << Q_W);
      q_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    localparam int B = Q_W - j;

    logic [LW-1:0]  t;
    logic           take;
    logic [Q_W-1:0] q_nx;

    assign t    = n_ext << (B + 1);
    assign take = (r_q[j-1] >= t);

    always_comb begin
      q_nx    = q_q[j-1];
      q_nx[B] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en[1+j]) begin
        r_q[j] <= take ? (r_q[j-1] - t) : r_q[j-1];
        q_q[j] <= q_nx;
      end
    end
  end

endmodule

// File: src/pam_hd_ser.sv
module pam_hd_ser #(
  parameter int MAX_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pam_hd_pkg::cfg_t             cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [MAX_BITS-1:0]          idx_i,
  input  logic [pam_hd_pkg::LVL_W-1:0] level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         bit_o,
  output logic [pam_hd_pkg::LVL_W-1:0] level_o,
  output logic                         last_o
);

  localparam int CW = $clog2(MAX_BITS + 1);

  logic                         full_q;
  logic [MAX_BITS-1:0]          sr_q;
  logic [CW-1:0]                cnt_q;
  logic [pam_hd_pkg::LVL_W-1:0] lvl_q;
  logic                         load;

  assign last_o      = (cnt_q == '0);
  assign in_ready_o  = !full_q || (out_ready_i && last_o);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = full_q;
  assign bit_o       = cfg_i.msb_first ? sr_q[MAX_BITS-1] : sr_q[0];
  assign level_o     = lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      full_q <= 1'b1;
      cnt_q  <= CW'(cfg_i.nb - 1'b1);
    end else if (full_q && out_ready_i) begin
      if (last_o) begin
        full_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sr_q  <= cfg_i.msb_first ? (idx_i << (MAX_BITS - int'(cfg_i.nb))) : idx_i;
      lvl_q <= level_i;
    end else if (full_q && out_ready_i) begin
      sr_q <= cfg_i.msb_first ? (sr_q << 1) : (sr_q >> 1);
    end
  end

endmodule

// File: src/pam_hard_demapper_top.sv
// Throughput: one result word per cycle while out_if.ready is high; each sample yields num_bits
//   words (default 4, clamped to 1..MAX_BITS), so the output serializer takes a new sample only
//   when it is empty or the last word of the previous sample is being accepted.
// Datapath: MAX_BITS + 3 stage index search, 19 stage level divider, output register.
// Reset: pipeline emptied, registers back to num_bits 4, msb_first 1, levels +/-1.0.
module pam_hard_demapper_top #(
  parameter int MAX_BITS     = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pam_hd_cfg_if.sink  cfg_if,
  pam_hd_in_if.sink   in_if,
  pam_hd_out_if.source out_if
);

  localparam int LVL_W = pam_hd_pkg::LVL_W;

  pam_hd_pkg::cfg_t    cfg;
  logic                idx_valid;
  logic                idx_ready;
  logic [MAX_BITS-1:0] idx;
  logic                lvl_valid;
  logic                lvl_ready;
  logic [MAX_BITS-1:0] lvl_idx;
  logic [LVL_W-1:0]    lvl;

  assign cfg_if.ready = 1'b1;

  pam_hd_cfg #(
    .MAX_BITS (MAX_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_if.valid),
    .wr_addr_i  (cfg_if.addr),
    .wr_data_i  (cfg_if.data),
    .cfg_o      (cfg)
  );

  pam_hd_idx #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_BITS     (MAX_BITS)
  ) u_idx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .sample_i    (in_if.sample),
    .out_valid_o (idx_valid),
    .out_ready_i (idx_ready),
    .idx_o       (idx)
  );

  pam_hd_lvl #(
    .MAX_BITS (MAX_BITS)
  ) u_lvl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (idx_valid),
    .in_ready_o  (idx_ready),
    .idx_i       (idx),
    .out_valid_o (lvl_valid),
    .out_ready_i (lvl_ready),
    .idx_o       (lvl_idx),
    .level_o     (lvl)
  );

  pam_hd_ser #(
    .MAX_BITS (MAX_BITS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (lvl_valid),
    .in_ready_o  (lvl_ready),
    .idx_i       (lvl_idx),
    .level_i     (lvl),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .bit_o       (out_if.bit_res),
    .level_o     (out_if.level),
    .last_o      (out_if.last)
  );

endmodule

// File: sim/tb_pam_hard_demapper_top.sv
module tb_pam_hard_demapper_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LVL_W      = pam_hd_pkg::LVL_W;
  localparam int NB_W       = pam_hd_pkg::NB_W;
  localparam int MAX_BITS   = 8;
  localparam int SAMPLE_W   = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    logic             bit_res;
    logic [LVL_W-1:0] level;
    logic             last;
  } demap_word_t;

  // Expected bit, level and last flag per output word, checked in order against the output words.
  class pam_word_checker;
    demap_word_t           expected_words[$];
    logic [NB_W-1:0]       nb_q   = pam_hd_pkg::NUM_BITS_RST;
    logic                  msb_q  = pam_hd_pkg::MSB_FIRST_RST;
    logic signed [LVL_W-1:0] hi_q = pam_hd_pkg::HIGH_LEVEL_RST;
    logic signed [LVL_W-1:0] lo_q = pam_hd_pkg::LOW_LEVEL_RST;
    int err_cnt = 0;

    function void set_reg(pam_hd_pkg::reg_idx_e idx, logic [LVL_W-1:0] data);
      case (idx)
        pam_hd_pkg::REG_NUM_BITS:   nb_q  = data[NB_W-1:0];
        pam_hd_pkg::REG_MSB_FIRST:  msb_q = data[0];
        pam_hd_pkg::REG_HIGH_LEVEL: hi_q  = data;
        pam_hd_pkg::REG_LOW_LEVEL:  lo_q  = data;
        default: ;
      endcase
    endfunction

    function longint floor_quot(longint num, longint den);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      longint x, hi, lo, n, d, idx, lvl;
      int nb, sh;
      demap_word_t w;
      x  = $signed(s);
      hi = hi_q;
      lo = lo_q;
      nb = nb_q;
      if (nb < 1) nb = 1;
      if (nb > MAX_BITS) nb = MAX_BITS;
      n = (longint'(1) << nb) - 1;
      d = hi - lo;
      if (d == 0) begin
        idx = 0;
        lvl = lo;
      end else begin
        idx = floor_quot(2 * (x - lo) * n + d, 2 * d);
        if (idx < 0) idx = 0;
        if (idx > n) idx = n;
        lvl = lo + floor_quot(2 * idx * d + n, 2 * n);
      end
      for (int b = 0; b < nb; b++) begin
        sh = msb_q ? (nb - 1 - b) : b;
        w.bit_res = idx[sh];
        w.level   = lvl[LVL_W-1:0];
        w.last    = (b == nb - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic b, logic [LVL_W-1:0] lv, logic l);
      demap_word_t w;
      if (expected_words.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected word: bit %0b level %0d last %0b", b, $signed(lv), l);
        return;
      end
      w = expected_words.pop_front();
      if (w.bit_res !== b || w.level !== lv || w.last !== l) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: exp bit %0b level %0d last %0b, got bit %0b level %0d last %0b",
                   w.bit_res, $signed(w.level), w.last, b, $signed(lv), l);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pam_hd_cfg_if                          cfg_if ();
  pam_hd_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
  pam_hd_out_if                          out_if ();

  pam_hard_demapper_top #(
    .MAX_BITS    (MAX_BITS),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_if(cfg_if),
    .in_if (in_if),
    .out_if(out_if)
  );

  pam_word_checker sb = new();

  logic in_idle_en;
  logic out_stall_en;
  logic [SAMPLE_W-1:0] plan[$];
  int idle_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap(bit long_ok);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90 || !long_ok) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output back-pressure: alternating ready and stall stretches while out_stall_en is set, else always ready.
  initial begin
    int hold;
    logic rdy;
    hold = 0;
    rdy  = 1'b1;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        if (out_stall_en && rdy) begin
          rdy  = 1'b0;
          hold = pick_gap(1'b1);
          if (hold == 0) hold = 1;
        end else begin
          rdy  = 1'b1;
          hold = $urandom_range(1, 12);
        end
      end
      hold--;
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word(out_if.bit_res, out_if.level, out_if.last);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [LVL_W-1:0] nb_w, msb_w, hi_w, lo_w);
    pam_hd_pkg::reg_idx_e ids[4];
    logic [LVL_W-1:0] vals[4];
    ids  = '{pam_hd_pkg::REG_NUM_BITS, pam_hd_pkg::REG_MSB_FIRST,
             pam_hd_pkg::REG_HIGH_LEVEL, pam_hd_pkg::REG_LOW_LEVEL};
    vals = '{nb_w, msb_w, hi_w, lo_w};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.addr  <= ids[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.set_reg(ids[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = in_idle_en ? pick_gap(1'b1) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(s);
  endtask

  task automatic run_phase(input logic [LVL_W-1:0] nb_w, msb_w, hi_w, lo_w);
    wait_drained();
    apply_config(nb_w, msb_w, hi_w, lo_w);
    in_idle_en   = ($urandom_range(0, 3) != 0);
    out_stall_en = ($urandom_range(0, 3) != 0);
    foreach (plan[i]) send_sample(plan[i]);
    in_if.valid <= 1'b0;
    plan.delete();
  endtask

  // Mostly within 512 of the level span or near decision points, some anywhere.
  function automatic logic [SAMPLE_W-1:0] rand_sample(int hi, int lo, int nb);
    int r, n, k, mn, mx, v;
    if (nb < 1) nb = 1;
    if (nb > MAX_BITS) nb = MAX_BITS;
    n  = (1 << nb) - 1;
    mn = (hi < lo) ? hi : lo;
    mx = (hi < lo) ? lo : hi;
    r  = $urandom_range(0, 9);
    if (r < 2) return SAMPLE_W'($urandom);
    if (r < 5 && hi != lo) begin
      k = $urandom_range(0, n - 1);
      v = lo + ((2 * k + 1) * (hi - lo)) / (2 * n) + int'($urandom_range(0, 4)) - 2;
    end else begin
      v = mn - 512 + int'($urandom_range(0, mx - mn + 1024));
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[SAMPLE_W-1:0];
  endfunction

  initial begin
    int nb, hi, lo, a, b, m;
    logic [LVL_W-1:0] nb_w;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.addr   = '0;
    cfg_if.data   = '0;
    in_idle_en    = 1'b0;
    out_stall_en  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default spacing, rails and points next to a decision boundary
    plan = '{16'h8000, 16'h7FFF, 16'h0000, 16'hF000, 16'h1000, 16'hFFFF, 16'h0001,
             16'hF111, 16'hF112};
    run_phase(16'h0004, 16'h0001, 16'h1000, 16'hF000);
    // equal levels
    plan = '{16'h8000, 16'h7FFF, 16'h0400};
    run_phase(16'h0003, 16'h0000, 16'h0400, 16'h0400);
    // reversed levels
    plan = '{16'h2000, 16'hE000, 16'h0000, 16'h7FFF, 16'h8000};
    run_phase(16'h0002, 16'h0001, 16'hE000, 16'h2000);
    // zero bits, full-scale levels
    plan = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    run_phase(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000);
    // bit count above max, LSB first
    plan = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0080};
    run_phase(16'hFFFF, 16'hFFFE, 16'h7FFF, 16'h8000);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 99) < 85) nb = $urandom_range(1, 8);
      else if ($urandom_range(0, 1) != 0) nb = 0;
      else nb = $urandom_range(9, 15);
      nb_w = {12'($urandom), 4'(nb)};
      a = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
      m = $urandom_range(0, 9);
      if (m <= 5) begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end else if (m == 6) begin
        lo = a;
        hi = a;
      end else if (m == 7) begin
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end else if (m == 8) begin
        lo = -32768;
        hi = 32767;
      end else begin
        lo = a;
        hi = b;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) plan.push_back(rand_sample(hi, lo, nb));
      run_phase(nb_w, 16'($urandom), hi[LVL_W-1:0], lo[LVL_W-1:0]);
    end

    wait_drained();
    repeat (MAX_BITS + 32) @(posedge clk_i);
    if (sb.err_cnt == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
